### rtl/rbb_pkg.sv
`default_nettype none

package rbb_pkg;

  localparam int POS_W   = 32;
  localparam int ANG_W   = 16;
  localparam int TRIG_W  = 18;
  localparam int BOX_W   = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Fraction bits of cos/sin; the half extent adds one more shift
  localparam int TRIG_BITS = 16;

  // Pipeline depth of each unit
  localparam int TRIG_LAT = 6;
  localparam int CRN_LAT  = 4;

  localparam logic signed [TRIG_W-1:0] TRIG_ONE_S = 18'sd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_WIDTH  = 2'd0,
    CFG_BOX_HEIGHT = 2'd1,
    CFG_COLLIDER   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_rot;
    logic signed [TRIG_W-1:0] sin_rot;
  } trig_t;

endpackage

`default_nettype wire

### rtl/rbb_trig.sv
`default_nettype none

// Cosine and sine of a binary angle. Two quarter-wave lanes run side by
// side (r and quarter-r), one multiply per stage, then a quadrant fold.
module rbb_trig (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rbb_pkg::ANG_W-1:0]  angle,
  output rbb_pkg::trig_t             trig
);
  import rbb_pkg::*;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  localparam logic [14:0] QUARTER  = 15'd16384;
  localparam logic [16:0] POLY_C1  = 17'd102944;
  localparam logic [15:0] POLY_C2  = 16'd42048;
  localparam logic [12:0] POLY_C3  = 13'd4640;
  localparam logic [16:0] TRIG_ONE = 17'd65536;

  logic [14:0] k_lane [2];

  quad_t       q_s1, q_s2, q_s3, q_s4, q_s5;
  logic [16:0] x_s1  [2];
  logic [16:0] x_s2  [2];
  logic [16:0] x2_s2 [2];
  logic [16:0] x_s3  [2];
  logic [16:0] x2_s3 [2];
  logic [12:0] t_s3  [2];
  logic [16:0] x_s4  [2];
  logic [15:0] v_s4  [2];
  logic [16:0] s_s5  [2];

  logic [33:0] sq   [2];
  logic [29:0] tp   [2];
  logic [15:0] u_c  [2];
  logic [32:0] vp   [2];
  logic [16:0] w_c  [2];
  logic [33:0] sp   [2];

  logic signed [TRIG_W-1:0] a_pos, a_neg, b_pos, b_neg;
  trig_t trig_next;

  assign k_lane[0] = {1'b0, angle[13:0]};
  assign k_lane[1] = QUARTER - {1'b0, angle[13:0]};

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sq[l]  = 34'(x_s1[l]) * 34'(x_s1[l]);
      tp[l]  = 30'(x2_s2[l]) * 30'(POLY_C3);
      u_c[l] = POLY_C2 - {3'b000, t_s3[l]};
      vp[l]  = 33'(x2_s3[l]) * 33'(u_c[l]);
      w_c[l] = POLY_C1 - {1'b0, v_s4[l]};
      sp[l]  = 34'(x_s4[l]) * 34'(w_c[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_s1 <= quad_t'(angle[15:14]);
      q_s2 <= q_s1;
      q_s3 <= q_s2;
      q_s4 <= q_s3;
      q_s5 <= q_s4;
      for (int l = 0; l < 2; l++) begin
        x_s1[l]  <= {k_lane[l], 2'b00};
        x_s2[l]  <= x_s1[l];
        x2_s2[l] <= sq[l][32:16];
        x_s3[l]  <= x_s2[l];
        x2_s3[l] <= x2_s2[l];
        t_s3[l]  <= tp[l][28:16];
        x_s4[l]  <= x_s3[l];
        v_s4[l]  <= vp[l][31:16];
        s_s5[l]  <= (sp[l][33:16] > {1'b0, TRIG_ONE}) ? TRIG_ONE : sp[l][32:16];
      end
      trig <= trig_next;
    end
  end

  assign a_pos = signed'({1'b0, s_s5[0]});
  assign b_pos = signed'({1'b0, s_s5[1]});
  assign a_neg = -a_pos;
  assign b_neg = -b_pos;

  always_comb begin
    unique case (q_s5)
      QUAD_0: begin
        trig_next.sin_rot = a_pos;
        trig_next.cos_rot = b_pos;
      end
      QUAD_1: begin
        trig_next.sin_rot = b_pos;
        trig_next.cos_rot = a_neg;
      end
      QUAD_2: begin
        trig_next.sin_rot = a_neg;
        trig_next.cos_rot = b_neg;
      end
      QUAD_3: begin
        trig_next.sin_rot = b_neg;
        trig_next.cos_rot = a_pos;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/rbb_corners.sv
`default_nettype none

// Rotated corner offsets, corner positions and the min/max reduction.
module rbb_corners (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [rbb_pkg::POS_W-1:0]  pos_x,
  input  logic signed [rbb_pkg::POS_W-1:0]  pos_y,
  input  rbb_pkg::trig_t                    trig,
  input  logic        [rbb_pkg::BOX_W-1:0]  box_width,
  input  logic        [rbb_pkg::BOX_W-1:0]  box_height,
  output logic signed [rbb_pkg::POS_W-1:0]  min_x,
  output logic signed [rbb_pkg::POS_W-1:0]  min_y,
  output logic signed [rbb_pkg::POS_W-1:0]  max_x,
  output logic signed [rbb_pkg::POS_W-1:0]  max_y,
  output rbb_pkg::trig_t                    trig_out
);
  import rbb_pkg::*;

  localparam int PROD_W = BOX_W + 1 + TRIG_W;
  // bits of the offset after the floor shift by TRIG_BITS+1 (halving folded in)
  localparam int SH_LO = TRIG_BITS + 1;
  localparam int SH_HI = SH_LO + POS_W - 1;

  // corner signs: bit set means +1; corners (-,-) (+,-) (+,+) (-,+)
  localparam logic [3:0] SGX_POS = 4'b0110;
  localparam logic [3:0] SGY_POS = 4'b1100;

  logic signed [PROD_W-1:0] wc, ws, hc, hs;
  logic signed [POS_W-1:0]  px_c1, py_c1, px_c2, py_c2;
  trig_t                    trig_c1, trig_c2, trig_c3;

  logic signed [PROD_W-1:0] ox [4];
  logic signed [PROD_W-1:0] oy [4];
  logic        [POS_W-1:0]  dx_c2 [4];
  logic        [POS_W-1:0]  dy_c2 [4];
  logic signed [POS_W-1:0]  vx_c3 [4];
  logic signed [POS_W-1:0]  vy_c3 [4];

  logic signed [POS_W-1:0]  mnx_a, mnx_b, mxx_a, mxx_b;
  logic signed [POS_W-1:0]  mny_a, mny_b, mxy_a, mxy_b;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ox[i] = (SGX_POS[i] ? wc : -wc) - (SGY_POS[i] ? hs : -hs);
      oy[i] = (SGX_POS[i] ? ws : -ws) + (SGY_POS[i] ? hc : -hc);
    end
  end

  always_comb begin
    mnx_a = (vx_c3[0] < vx_c3[1]) ? vx_c3[0] : vx_c3[1];
    mnx_b = (vx_c3[2] < vx_c3[3]) ? vx_c3[2] : vx_c3[3];
    mxx_a = (vx_c3[0] > vx_c3[1]) ? vx_c3[0] : vx_c3[1];
    mxx_b = (vx_c3[2] > vx_c3[3]) ? vx_c3[2] : vx_c3[3];
    mny_a = (vy_c3[0] < vy_c3[1]) ? vy_c3[0] : vy_c3[1];
    mny_b = (vy_c3[2] < vy_c3[3]) ? vy_c3[2] : vy_c3[3];
    mxy_a = (vy_c3[0] > vy_c3[1]) ? vy_c3[0] : vy_c3[1];
    mxy_b = (vy_c3[2] > vy_c3[3]) ? vy_c3[2] : vy_c3[3];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wc      <= PROD_W'(signed'({1'b0, box_width})  * trig.cos_rot);
      ws      <= PROD_W'(signed'({1'b0, box_width})  * trig.sin_rot);
      hc      <= PROD_W'(signed'({1'b0, box_height}) * trig.cos_rot);
      hs      <= PROD_W'(signed'({1'b0, box_height}) * trig.sin_rot);
      px_c1   <= pos_x;
      py_c1   <= pos_y;
      trig_c1 <= trig;

      for (int i = 0; i < 4; i++) begin
        dx_c2[i] <= ox[i][SH_HI:SH_LO];
        dy_c2[i] <= oy[i][SH_HI:SH_LO];
      end
      px_c2   <= px_c1;
      py_c2   <= py_c1;
      trig_c2 <= trig_c1;

      // wraps modulo 2^32
      for (int i = 0; i < 4; i++) begin
        vx_c3[i] <= signed'(px_c2 + dx_c2[i]);
        vy_c3[i] <= signed'(py_c2 + dy_c2[i]);
      end
      trig_c3 <= trig_c2;

      min_x    <= (mnx_a < mnx_b) ? mnx_a : mnx_b;
      max_x    <= (mxx_a > mxx_b) ? mxx_a : mxx_b;
      min_y    <= (mny_a < mny_b) ? mny_a : mny_b;
      max_y    <= (mxy_a > mxy_b) ? mxy_a : mxy_b;
      trig_out <= trig_c3;
    end
  end

endmodule

`default_nettype wire

### rtl/rotated_box_bounds.sv
`default_nettype none

// Axis-aligned bounds of a rotated box. Each transfer on s_axis carries a
// centre and a binary angle; one result per item leaves on m_axis, one item
// per cycle sustained while m_tready stays high. The depth comes from the
// trig unit (six stages, four of them with one multiply each) followed by the
// corner unit (products, offsets, corner sums, min/max). The whole pipeline
// advances together: a stall on m_tready freezes every stage and drops s_tready
// in the same cycle. The cfg port is always ready; write it only when idle.
module rotated_box_bounds (
  input  logic                              clk,
  input  logic                              rst,
  // pos_x[31:0], pos_y[63:32], angle[79:64]
  input  logic [79:0]                       s_tdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // min_x[31:0], min_y[63:32], max_x[95:64], max_y[127:96],
  // cos_rot[145:128], sin_rot[163:146], normals_valid[164]
  output logic [167:0]                      m_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rbb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rbb_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rbb_pkg::*;

  localparam int LAT = TRIG_LAT + CRN_LAT;

  logic [BOX_W-1:0] box_width, box_height;
  logic             collider_is_quad;

  logic [LAT-1:0]   vld;
  logic             en;

  logic signed [POS_W-1:0] px_dly [TRIG_LAT];
  logic signed [POS_W-1:0] py_dly [TRIG_LAT];

  trig_t                   trig, trig_out;
  logic signed [POS_W-1:0] min_x, min_y, max_x, max_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_width        <= BOX_W'(65536);
      box_height       <= BOX_W'(65536);
      collider_is_quad <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BOX_WIDTH:  box_width        <= cfg_data[BOX_W-1:0];
        CFG_BOX_HEIGHT: box_height       <= cfg_data[BOX_W-1:0];
        CFG_COLLIDER:   collider_is_quad <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline moves whenever the output slot is free or being drained
  assign en       = !vld[LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_dly[0] <= signed'(s_tdata[31:0]);
      py_dly[0] <= signed'(s_tdata[63:32]);
      for (int i = 1; i < TRIG_LAT; i++) begin
        px_dly[i] <= px_dly[i-1];
        py_dly[i] <= py_dly[i-1];
      end
    end
  end

  rbb_trig u_trig (
    .clk   (clk),
    .en    (en),
    .angle (s_tdata[79:64]),
    .trig  (trig)
  );

  rbb_corners u_corners (
    .clk        (clk),
    .en         (en),
    .pos_x      (px_dly[TRIG_LAT-1]),
    .pos_y      (py_dly[TRIG_LAT-1]),
    .trig       (trig),
    .box_width  (box_width),
    .box_height (box_height),
    .min_x      (min_x),
    .min_y      (min_y),
    .max_x      (max_x),
    .max_y      (max_y),
    .trig_out   (trig_out)
  );

  assign m_tdata = {3'b000, collider_is_quad, trig_out.sin_rot, trig_out.cos_rot,
                    max_y, max_x, min_y, min_x};

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while output stalled");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_last_stage_moves: assert property (@(posedge clk) disable iff (rst)
    en && vld[LAT-2] |=> m_tvalid)
    else $error("item lost before output stage");

  a_trig_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (trig_out.cos_rot <= TRIG_ONE_S && trig_out.cos_rot >= -TRIG_ONE_S
                  && trig_out.sin_rot <= TRIG_ONE_S && trig_out.sin_rot >= -TRIG_ONE_S))
    else $error("cos/sin outside unit range");

endmodule

`default_nettype wire

### tb/sv/rbb_bounds_check_pkg.sv
package rbb_bounds_check_pkg;

  import rbb_pkg::*;

  typedef struct {
    logic signed [POS_W-1:0]  min_x;
    logic signed [POS_W-1:0]  min_y;
    logic signed [POS_W-1:0]  max_x;
    logic signed [POS_W-1:0]  max_y;
    logic signed [TRIG_W-1:0] cos_rot;
    logic signed [TRIG_W-1:0] sin_rot;
    logic                     normals_valid;
  } box_bounds_t;

  // Polynomial quarter-wave sine, k in 0..16384 maps to 0..pi/2, Q1.16 result
  function automatic longint quarter_sine(int unsigned k);
    longint unsigned x, x2, u, w, s;
    x  = 64'(k) << 2;
    x2 = (x * x) >> 16;
    u  = 64'd42048 - ((64'd4640 * x2) >> 16);
    w  = 64'd102944 - ((x2 * u) >> 16);
    s  = (x * w) >> 16;
    if (s > 64'd65536) s = 64'd65536;
    return longint'(s);
  endfunction

  class bounds_predictor;
    logic [BOX_W-1:0] box_width;
    logic [BOX_W-1:0] box_height;
    logic             is_quad;
    box_bounds_t      pending_bounds[$];
    int               errors;

    function new();
      box_width  = 31'd65536;
      box_height = 31'd65536;
      is_quad    = 1'b1;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_BOX_WIDTH:  box_width  = data[BOX_W-1:0];
        CFG_BOX_HEIGHT: box_height = data[BOX_W-1:0];
        CFG_COLLIDER:   is_quad    = data[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_bounds.size();
    endfunction

    function void note_body(logic [79:0] body);
      logic signed [POS_W-1:0] px, py, vx, vy;
      logic [ANG_W-1:0]        ang;
      int unsigned             r;
      longint                  a, b, c, s, wc, ws, hc, hs, ox, oy, dx, dy;
      int                      sx, sy;
      box_bounds_t             e;
      px  = body[31:0];
      py  = body[63:32];
      ang = body[79:64];
      r   = 32'(ang[13:0]);
      a   = quarter_sine(r);
      b   = quarter_sine(32'd16384 - r);
      case (ang[15:14])
        2'd0: begin s = a;  c = b;  end
        2'd1: begin s = b;  c = -a; end
        2'd2: begin s = -a; c = -b; end
        default: begin s = -b; c = a; end
      endcase
      wc = longint'({33'd0, box_width}) * c;
      ws = longint'({33'd0, box_width}) * s;
      hc = longint'({33'd0, box_height}) * c;
      hs = longint'({33'd0, box_height}) * s;
      e  = '{default: '0};
      for (int i = 0; i < 4; i++) begin
        sx = (i == 1 || i == 2) ? 1 : -1;
        sy = (i >= 2) ? 1 : -1;
        ox = sx * wc - sy * hs;
        oy = sx * ws + sy * hc;
        // half extent folded into the shift; >>> floors negative offsets
        dx = ox >>> (TRIG_BITS + 1);
        dy = oy >>> (TRIG_BITS + 1);
        vx = px + dx[31:0];
        vy = py + dy[31:0];
        if (i == 0) begin
          e.min_x = vx; e.max_x = vx; e.min_y = vy; e.max_y = vy;
        end else begin
          if (vx < e.min_x) e.min_x = vx;
          if (vx > e.max_x) e.max_x = vx;
          if (vy < e.min_y) e.min_y = vy;
          if (vy > e.max_y) e.max_y = vy;
        end
      end
      e.cos_rot       = c[TRIG_W-1:0];
      e.sin_rot       = s[TRIG_W-1:0];
      e.normals_valid = is_quad;
      pending_bounds.push_back(e);
    endfunction

    function void compare_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_bounds(logic [167:0] d);
      box_bounds_t e;
      if (pending_bounds.size() == 0) begin
        errors++;
        $display("%0t: result with no body pending, expected none actual %h", $time, d);
        return;
      end
      e = pending_bounds.pop_front();
      compare_field("min_x", e.min_x, $signed(d[31:0]));
      compare_field("min_y", e.min_y, $signed(d[63:32]));
      compare_field("max_x", e.max_x, $signed(d[95:64]));
      compare_field("max_y", e.max_y, $signed(d[127:96]));
      compare_field("cos_rot", e.cos_rot, $signed(d[145:128]));
      compare_field("sin_rot", e.sin_rot, $signed(d[163:146]));
      compare_field("normals_valid", e.normals_valid, d[164]);
    endfunction
  endclass

endpackage

### tb/sv/rotated_box_bounds_tb.sv
module rotated_box_bounds_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import rbb_pkg::*;
  import rbb_bounds_check_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 300;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [79:0]           s_tdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [167:0]          m_tdata;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;
  bit hold_active = 1'b0;
  int idle_cycles;

  bounds_predictor bounds = new();

  rotated_box_bounds u_top (
    .clk(clk),
    .rst(rst),
    .s_tdata(s_tdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata(m_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) bounds.note_body(s_tdata);
      if (m_tvalid && m_tready) bounds.check_bounds(m_tdata);
      if (cfg_valid && cfg_ready) bounds.write_reg(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // mostly short stalls, a few long ones
  function automatic int stall_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin : receiver
    int len;
    logic ready;
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        hold_active = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
        hold_active = 1'b0;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin ready = 1'b0; len = stall_length(); end
          3: begin ready = 1'b1; len = $urandom_range(50, 150); end
          default: begin ready = 1'b1; len = $urandom_range(1, 8); end
        endcase
        m_tready <= ready;
        repeat (len) @(posedge clk);
      end
    end
  end

  function automatic logic [79:0] pack_body(logic [31:0] x, logic [31:0] y, logic [15:0] a);
    return {a, y, x};
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 9))
      0, 1: return 32'h7FFF_FFFF - $urandom_range(0, 32'h0004_0000);
      2, 3: return 32'h8000_0000 + $urandom_range(0, 32'h0004_0000);
      4, 5: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    logic [31:0] v;
    // near the quadrant boundaries now and then
    if ($urandom_range(0, 4) == 0)
      v = $urandom_range(0, 3) * 32'd16384 + $urandom_range(0, 4) - 32'd2;
    else
      v = $urandom();
    return v[15:0];
  endfunction

  function automatic logic [31:0] rand_extent();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom_range(0, 32'h0040_0000);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(input logic [79:0] body);
    int gap;
    gap = (!gaps_on || $urandom_range(0, 99) < 65) ? 0 : stall_length();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= body;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++)
      send_item(pack_body(rand_pos(), rand_pos(), rand_angle()));
  endtask

  task automatic send_key_angles(input int n);
    logic [15:0] key_angles[13];
    logic [31:0] key_pos[6];
    key_angles = '{16'd0, 16'd1, 16'd8192, 16'd16383, 16'd16384, 16'd16385, 16'd24576,
                   16'd32767, 16'd32768, 16'd40960, 16'd49152, 16'd57344, 16'd65535};
    key_pos = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                32'h7FFF_8000, 32'h0001_0000};
    for (int i = 0; i < n; i++)
      send_item(pack_body(key_pos[i % 6], key_pos[(i + 3) % 6], key_angles[i]));
  endtask

  // let the pipeline empty before touching the registers
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (bounds.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic apply_config(input logic [31:0] w, input logic [31:0] h, input bit quad);
    logic [CFG_IDX_W-1:0]  idx[4];
    logic [CFG_DATA_W-1:0] vals[4];
    logic [31:0]           rnd;
    drain();
    rnd  = $urandom();
    idx  = '{CFG_BOX_WIDTH, CFG_BOX_HEIGHT, CFG_COLLIDER, CFG_SPARE};
    vals = '{w, h, {rnd[31:1], quad}, $urandom()};
    for (int i = 0; i < 4; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset configuration: unit box, quad collider
    send_key_angles(13);
    send_item(pack_body(32'h7FFF_FFFF, 32'h8000_0000, 16'd8191));
    send_item(pack_body(32'h8000_0000, 32'h7FFF_FFFF, 16'd49153));
    send_item(pack_body(32'hFFFF_FFFF, 32'h0000_0000, 16'd32769));

    // widest box, the top bit of the data is dropped
    apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_key_angles(8);
    send_random(30);

    apply_config(32'd0, 32'd0, 1'b1);
    send_key_angles(8);
    send_random(30);

    // odd extents, the half bit is floored away by the shift
    apply_config(32'd1, 32'd3, 1'b0);
    send_random(30);

    // receiver holds off while the sender keeps offering back to back
    apply_config(32'h8000_0001, rand_extent(), 1'($urandom_range(0, 1)));
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    while (!hold_active) @(posedge clk);
    send_random(60);
    gaps_on = 1'b1;

    for (int p = 0; p < 8; p++) begin
      apply_config(rand_extent(), rand_extent(), 1'($urandom_range(0, 1)));
      gaps_on = ($urandom_range(0, 2) != 0);
      send_random(40);
    end

    drain();
    repeat (8) @(posedge clk);
    if (bounds.errors == 0 && bounds.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
